FILE: sv/lir_pkg.sv
package lir_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 24;

  // Width of the step register and of the phase accumulator. The phase stays
  // below one before each add, so one bit above the step width is enough.
  localparam int STEP_W  = 32;
  localparam int PHASE_W = STEP_W + 1;

  // Longest run of results that one input sample may cause.
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = $clog2(MAX_RESULTS);

endpackage

FILE: sv/linear_interp_resampler_unit.sv
// Linear-interpolation sample-rate converter. Each input item is one audio
// sample; the block keeps the previous sample and a phase with FRAC_BITS
// fraction bits measured from it. The first sample after reset (or after a
// change of the step register) is only stored. For each later sample the
// block emits prev*(1-f)+new*f, truncated toward zero, while the phase f is
// below one, adding the step after each result; the final result of a run
// carries last_of_run. A run ends after at most 64 results. The step
// register (cfg_wr_data, UQ8.24 input rate over output rate) resets to 1.0;
// writing a different value clears the sample history and the phase, and it
// must be written only while the block is idle. An input that causes no
// result is taken while the block stays idle. Otherwise each result passes
// through a multiply state, an add-and-truncate state, and a wait state in
// the output register until out_ready takes it; in_ready stays low until the
// final result of the run is taken, as the single shared interpolation unit
// is reused for every result.
module linear_interp_resampler_unit #(
  parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = lir_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  output logic                          out_last_of_run,
  input  logic                          cfg_wr_en,
  input  logic [lir_pkg::STEP_W-1:0]    cfg_wr_data
);

  localparam int PW = lir_pkg::PHASE_W;
  localparam int CW = lir_pkg::CNT_W;

  localparam logic [PW-1:0] PHASE_ONE = PW'(1) << FRAC_BITS;
  localparam logic [lir_pkg::STEP_W-1:0] STEP_RESET = lir_pkg::STEP_W'(1) << FRAC_BITS;
  localparam logic [CW-1:0] CNT_LAST = CW'(lir_pkg::MAX_RESULTS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_SUM,
    ST_WAIT
  } state_t;

  state_t                        state_r;
  logic [lir_pkg::STEP_W-1:0]    step_r;
  logic signed [SAMPLE_BITS-1:0] prev_r;
  logic signed [SAMPLE_BITS-1:0] cur_r;
  logic [PW-1:0]                 phase_r;
  logic                          primed_r;
  logic [CW-1:0]                 cnt_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic                          out_last_r;

  logic                          unit_start;
  logic signed [SAMPLE_BITS-1:0] unit_y;
  logic [PW-1:0]                 phase_add;
  logic                          phase_ge_one;
  logic                          add_ge_one;
  logic                          run_last;

  // The shared interpolation unit: it takes its operands in the multiply
  // cycle and delivers the truncated result in the following cycle.
  lir_interp #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_interp (
    .clk  (clk),
    .start(unit_start),
    .prev (prev_r),
    .cur  (cur_r),
    .frac (phase_r[FRAC_BITS-1:0]),
    .y    (unit_y)
  );

  assign unit_start   = (state_r == ST_CALC);
  assign phase_ge_one = |phase_r[PW-1:FRAC_BITS];
  assign phase_add    = phase_r + PW'(step_r);
  assign add_ge_one   = |phase_add[PW-1:FRAC_BITS];

  // The run ends when the next phase reaches one or the result limit is hit.
  assign run_last = add_ge_one || (cnt_r == CNT_LAST);

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_sample_out  = out_sample_r;
  assign out_last_of_run = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= STEP_RESET;
      prev_r      <= '0;
      phase_r     <= '0;
      primed_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (cfg_wr_en && (cfg_wr_data != step_r)) begin
            // A new step restarts the converter from an empty history.
            step_r   <= cfg_wr_data;
            prev_r   <= '0;
            phase_r  <= '0;
            primed_r <= 1'b0;
          end else if (in_valid) begin
            if (!primed_r) begin
              prev_r   <= in_sample_in;
              primed_r <= 1'b1;
            end else if (phase_ge_one) begin
              // A large step skips this sample entirely.
              phase_r <= phase_r - PHASE_ONE;
              prev_r  <= in_sample_in;
            end else begin
              cur_r   <= in_sample_in;
              cnt_r   <= '0;
              state_r <= ST_CALC;
            end
          end
        end
        ST_CALC: begin
          state_r <= ST_SUM;
        end
        ST_SUM: begin
          out_sample_r <= unit_y;
          out_last_r   <= run_last;
          out_valid_r  <= 1'b1;
          cnt_r        <= cnt_r + CW'(1);
          if (run_last) begin
            // Close the run: step back by one, or restart at zero if the
            // result limit cut the run short.
            phase_r <= add_ge_one ? (phase_add - PHASE_ONE) : '0;
            prev_r  <= cur_r;
          end else begin
            phase_r <= phase_add;
          end
          state_r <= ST_WAIT;
        end
        ST_WAIT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r     <= out_last_r ? ST_IDLE : ST_CALC;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // The block never offers a result while it is taking a new item.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  // Every multiply is done on a phase below one.
  a_calc_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC) |-> !phase_ge_one)
    else $error("interpolation started with phase at or above one");

  // The add-and-truncate cycle always loads the output register.
  a_sum_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM) |=> out_valid)
    else $error("computed result was not presented");

  // Taking the marked result returns the block to accepting input.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_of_run) |=> in_ready)
    else $error("block not ready after the final result of a run");

  // When the next phase reaches one the run ends with that result.
  a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM && add_ge_one) |=> out_last_of_run)
    else $error("run did not end when the phase reached one");
`endif

endmodule

FILE: sv/lir_interp.sv
// Two-stage interpolation unit: a registered multiply of the sample
// difference by the phase fraction, then the add of the previous sample and
// a truncation toward zero.
module lir_interp #(
  parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = lir_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          start,
  input  logic signed [SAMPLE_BITS-1:0] prev,
  input  logic signed [SAMPLE_BITS-1:0] cur,
  input  logic        [FRAC_BITS-1:0]   frac,
  output logic signed [SAMPLE_BITS-1:0] y
);

  localparam int PW = SAMPLE_BITS + FRAC_BITS + 2;

  logic signed [SAMPLE_BITS:0]      diff;
  logic signed [FRAC_BITS:0]        frac_s;
  logic signed [PW-1:0]             prod_r;
  logic signed [SAMPLE_BITS-1:0]    prev_r;
  logic signed [PW-1:0]             acc;
  logic                             inc;

  assign diff   = $signed({cur[SAMPLE_BITS-1], cur}) - $signed({prev[SAMPLE_BITS-1], prev});
  assign frac_s = $signed({1'b0, frac});

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= diff * frac_s;
      prev_r <= prev;
    end
  end

  assign acc = prod_r + $signed({{2{prev_r[SAMPLE_BITS-1]}}, prev_r, {FRAC_BITS{1'b0}}});

  // A negative sum with a nonzero fraction rounds up by one toward zero.
  assign inc = acc[PW-1] & (|acc[FRAC_BITS-1:0]);
  assign y   = $signed(acc[FRAC_BITS+SAMPLE_BITS-1:FRAC_BITS]
                       + {{(SAMPLE_BITS-1){1'b0}}, inc});

endmodule
